// ===== sv/assert_macros.svh =====
// Assertion macros shared by the vertex update RTL.
// Used by the controller and the datapath; clocked on clk_i, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define KVU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define KVU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KVU_ASSERT(lbl, prop, msg)
`define KVU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/kvu_pkg.sv =====
// Types, constants, micro-program and fixed point helpers of the vertex update.
// No dependencies; imported by every module of the block.
package kvu_pkg;

  typedef enum logic [3:0] {
    OP_LD, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CHKZ, OP_CLU, OP_CLS,
    OP_WX, OP_WY, OP_WXX, OP_WXY, OP_WYY
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_WAIT, S_EMIT
  } ctrl_state_e;

  typedef logic [4:0] ridx_t;
  typedef logic [5:0] pc_t;

  // Scratch register file slots
  localparam ridx_t R_PX  = 5'd0;
  localparam ridx_t R_PY  = 5'd1;
  localparam ridx_t R_CXX = 5'd2;
  localparam ridx_t R_CXY = 5'd3;
  localparam ridx_t R_CYY = 5'd4;
  localparam ridx_t R_NS  = 5'd5;
  localparam ridx_t R_XR  = 5'd6;
  localparam ridx_t R_MM  = 5'd7;
  localparam ridx_t R_QM  = 5'd8;
  localparam ridx_t R_ME  = 5'd9;
  localparam ridx_t R_QE  = 5'd10;
  localparam ridx_t R_T0  = 5'd11;
  localparam ridx_t R_T1  = 5'd12;
  localparam ridx_t R_T2  = 5'd13;
  localparam ridx_t R_RV  = 5'd14;
  localparam ridx_t R_U0  = 5'd15;
  localparam ridx_t R_U1  = 5'd16;
  localparam ridx_t R_S   = 5'd17;
  localparam ridx_t R_IN  = 5'd18;
  localparam ridx_t R_K0  = 5'd19;
  localparam ridx_t R_K1  = 5'd20;
  localparam ridx_t R_NXX = 5'd21;
  localparam ridx_t R_NXY = 5'd22;
  localparam ridx_t R_NYY = 5'd23;
  localparam int    RF_DEPTH = 24;

  localparam logic [1:0] CFG_SLOPE_REF = 2'd0;
  localparam logic [1:0] CFG_X_REF     = 2'd1;
  localparam logic [1:0] CFG_SEED_X    = 2'd2;
  localparam logic [1:0] CFG_SEED_Y    = 2'd3;

  localparam pc_t PROG_LAST = 6'd58;
  localparam int  DIV_BITS  = 90;
  localparam int  DIV_CW    = $clog2(DIV_BITS + 1);

  localparam logic [47:0] SEED_COV = 48'd167772160000;
  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] U48_MAX = 64'sh0000_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] S48_MIN = 64'shFFFF_8000_0000_0000;

  typedef struct packed {
    op_e   op;
    ridx_t dst;
    ridx_t a;
    ridx_t b;
  } uop_t;

  typedef struct packed {
    logic capture;
    logic rd_en;
    logic go;
    logic load_out;
    uop_t uop;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
  } dp_stat_t;

  typedef struct packed {
    logic signed [31:0] slope_ref;
    logic signed [31:0] x_ref;
    logic signed [31:0] seed_x;
    logic signed [31:0] seed_y;
  } cfg_t;

  function automatic logic [63:0] magn(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] from_mag(input logic hi_nz, input logic [63:0] m,
                                                  input logic neg);
    logic signed [63:0] r;
    if (hi_nz) r = neg ? S64_MIN : S64_MAX;
    else if (neg) r = m[63] ? S64_MIN : -$signed(m);
    else r = m[63] ? S64_MAX : $signed(m);
    return r;
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] to_q16(input logic signed [63:0] v);
    logic [64:0] t;
    logic [56:0] m;
    logic signed [31:0] r;
    t = {1'b0, magn(v)} + 65'h80;
    m = t[64:8];
    if (v[63]) r = (m > 57'h8000_0000) ? 32'sh8000_0000 : -$signed(m[31:0]);
    else r = (m > 57'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(m[31:0]);
    return r;
  endfunction

  function automatic uop_t mk(input op_e op, input ridx_t d, input ridx_t a, input ridx_t b);
    uop_t u;
    u.op = op; u.dst = d; u.a = a; u.b = b;
    return u;
  endfunction

  // Micro-program of one update
  function automatic uop_t prog_row(input pc_t pc);
    uop_t u;
    unique case (pc)
      6'd0:  u = mk(OP_LD, R_PX, R_PX, R_PX);
      6'd1:  u = mk(OP_LD, R_PY, R_PY, R_PY);
      6'd2:  u = mk(OP_LD, R_CXX, R_CXX, R_CXX);
      6'd3:  u = mk(OP_LD, R_CXY, R_CXY, R_CXY);
      6'd4:  u = mk(OP_LD, R_CYY, R_CYY, R_CYY);
      6'd5:  u = mk(OP_LD, R_NS, R_NS, R_NS);
      6'd6:  u = mk(OP_LD, R_XR, R_XR, R_XR);
      6'd7:  u = mk(OP_LD, R_MM, R_MM, R_MM);
      6'd8:  u = mk(OP_LD, R_QM, R_QM, R_QM);
      6'd9:  u = mk(OP_LD, R_ME, R_ME, R_ME);
      6'd10: u = mk(OP_LD, R_QE, R_QE, R_QE);
      6'd11: u = mk(OP_CHKZ, R_T0, R_ME, R_ME);
      6'd12: u = mk(OP_CHKZ, R_T0, R_QE, R_QE);
      6'd13: u = mk(OP_MUL, R_T0, R_QE, R_QE);
      6'd14: u = mk(OP_MUL, R_T1, R_XR, R_XR);
      6'd15: u = mk(OP_MUL, R_T2, R_ME, R_ME);
      6'd16: u = mk(OP_MUL, R_T1, R_T1, R_T2);
      6'd17: u = mk(OP_ADD, R_RV, R_T0, R_T1);
      6'd18: u = mk(OP_MUL, R_T0, R_CXX, R_CYY);
      6'd19: u = mk(OP_MUL, R_T1, R_CXY, R_CXY);
      6'd20: u = mk(OP_SUB, R_T0, R_T0, R_T1);
      6'd21: u = mk(OP_CHKZ, R_T0, R_T0, R_T0);
      6'd22: u = mk(OP_MUL, R_T0, R_NS, R_CXX);
      6'd23: u = mk(OP_ADD, R_U0, R_T0, R_CXY);
      6'd24: u = mk(OP_MUL, R_T0, R_NS, R_CXY);
      6'd25: u = mk(OP_ADD, R_U1, R_T0, R_CYY);
      6'd26: u = mk(OP_MUL, R_T0, R_NS, R_U0);
      6'd27: u = mk(OP_ADD, R_T0, R_T0, R_U1);
      6'd28: u = mk(OP_ADD, R_S, R_T0, R_RV);
      6'd29: u = mk(OP_CHKZ, R_T0, R_S, R_S);
      6'd30: u = mk(OP_MUL, R_T0, R_XR, R_MM);
      6'd31: u = mk(OP_ADD, R_T0, R_QM, R_T0);
      6'd32: u = mk(OP_MUL, R_T1, R_NS, R_PX);
      6'd33: u = mk(OP_ADD, R_T1, R_T1, R_PY);
      6'd34: u = mk(OP_SUB, R_IN, R_T0, R_T1);
      6'd35: u = mk(OP_DIV, R_K0, R_U0, R_S);
      6'd36: u = mk(OP_DIV, R_K1, R_U1, R_S);
      6'd37: u = mk(OP_MUL, R_T0, R_K0, R_IN);
      6'd38: u = mk(OP_ADD, R_PX, R_PX, R_T0);
      6'd39: u = mk(OP_MUL, R_T0, R_K1, R_IN);
      6'd40: u = mk(OP_ADD, R_PY, R_PY, R_T0);
      6'd41: u = mk(OP_MUL, R_T0, R_K0, R_U0);
      6'd42: u = mk(OP_SUB, R_T0, R_CXX, R_T0);
      6'd43: u = mk(OP_CLU, R_NXX, R_T0, R_T0);
      6'd44: u = mk(OP_MUL, R_T0, R_K0, R_U1);
      6'd45: u = mk(OP_SUB, R_T0, R_CXY, R_T0);
      6'd46: u = mk(OP_CLS, R_NXY, R_T0, R_T0);
      6'd47: u = mk(OP_MUL, R_T0, R_K1, R_U1);
      6'd48: u = mk(OP_SUB, R_T0, R_CYY, R_T0);
      6'd49: u = mk(OP_CLU, R_NYY, R_T0, R_T0);
      6'd50: u = mk(OP_MUL, R_T0, R_NXX, R_NYY);
      6'd51: u = mk(OP_MUL, R_T1, R_NXY, R_NXY);
      6'd52: u = mk(OP_SUB, R_T0, R_T0, R_T1);
      6'd53: u = mk(OP_CHKZ, R_T0, R_T0, R_T0);
      6'd54: u = mk(OP_WX, R_T0, R_PX, R_PX);
      6'd55: u = mk(OP_WY, R_T0, R_PY, R_PY);
      6'd56: u = mk(OP_WXX, R_T0, R_NXX, R_NXX);
      6'd57: u = mk(OP_WXY, R_T0, R_NXY, R_NXY);
      6'd58: u = mk(OP_WYY, R_T0, R_NYY, R_NYY);
      default: u = mk(OP_CHKZ, R_T0, R_T0, R_T0);
    endcase
    return u;
  endfunction

endpackage

// ===== sv/kvu_cfg.sv =====
// APB register bank: slope_ref, x_ref, seed_x, seed_y.
// Depends on kvu_pkg.
module kvu_cfg
  import kvu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        CFG_SLOPE_REF: cfg_q.slope_ref <= pwdata;
        CFG_X_REF:     cfg_q.x_ref     <= pwdata;
        CFG_SEED_X:    cfg_q.seed_x    <= pwdata;
        CFG_SEED_Y:    cfg_q.seed_y    <= pwdata;
        default:       cfg_q           <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      CFG_SLOPE_REF: prdata = cfg_q.slope_ref;
      CFG_X_REF:     prdata = cfg_q.x_ref;
      CFG_SEED_X:    prdata = cfg_q.seed_x;
      CFG_SEED_Y:    prdata = cfg_q.seed_y;
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== sv/kvu_mul.sv =====
// Fixed point Q.24 multiplier: four 32x32 partial products, round, saturate.
// Depends on kvu_pkg.
module kvu_mul
  import kvu_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output logic               busy_o,
  output logic               done_o,
  output logic signed [63:0] res_o
);

  logic         run_q;
  logic [2:0]   cnt_q;
  logic [63:0]  ua_q, ub_q, prod_q;
  logic [127:0] acc_q, acc_r;
  logic         neg_q;
  logic [31:0]  a_h, b_h;
  logic [6:0]   sh;

  assign busy_o = run_q;
  assign done_o = run_q && (cnt_q == 3'd5);

  // Partial product order: lo*lo, lo*hi, hi*lo, hi*hi
  assign a_h = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
  assign b_h = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
  assign sh  = (cnt_q == 3'd1) ? 7'd0 : ((cnt_q == 3'd4) ? 7'd64 : 7'd32);

  assign acc_r = acc_q + 128'h80_0000;
  assign res_o = from_mag(|acc_r[127:88], acc_r[87:24], neg_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= '0;
    end else if (run_q) begin
      run_q <= !done_o;
      cnt_q <= cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q  <= magn(a_i);
      ub_q  <= magn(b_i);
      neg_q <= a_i[63] ^ b_i[63];
      acc_q <= '0;
    end else if (run_q) begin
      prod_q <= a_h * b_h;
      if (cnt_q != 3'd0 && cnt_q != 3'd5) acc_q <= acc_q + ({64'd0, prod_q} << sh);
    end
  end

endmodule

// ===== sv/kvu_div.sv =====
// Fixed point Q.24 divider, restoring, one quotient bit a cycle, rounded.
// Depends on kvu_pkg.
module kvu_div
  import kvu_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output logic               busy_o,
  output logic               done_o,
  output logic signed [63:0] res_o
);

  logic                run_q;
  logic [DIV_CW-1:0]   cnt_q;
  logic [DIV_BITS-1:0] dvd_q, quo_q;
  logic [63:0]         rem_q, ub_q;
  logic                neg_q;
  logic [64:0]         trial;
  logic                fits;
  logic [63:0]         ua;

  assign ua     = magn(a_i);
  assign busy_o = run_q;
  assign done_o = run_q && (cnt_q == DIV_CW'(DIV_BITS));
  assign trial  = {rem_q, dvd_q[DIV_BITS-1]};
  assign fits   = trial >= {1'b0, ub_q};
  assign res_o  = (ub_q == '0) ? '0 :
                  from_mag(|quo_q[DIV_BITS-1:64], quo_q[63:0], neg_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= '0;
    end else if (run_q) begin
      run_q <= !done_o;
      cnt_q <= cnt_q + DIV_CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ub_q  <= magn(b_i);
      neg_q <= a_i[63] ^ b_i[63];
      rem_q <= '0;
      quo_q <= '0;
      // dividend: |a| << 24 plus half the divisor for rounding
      dvd_q <= (DIV_BITS'(ua) << 24) + DIV_BITS'(magn(b_i) >> 1);
    end else if (run_q && !done_o) begin
      dvd_q <= dvd_q << 1;
      quo_q <= {quo_q[DIV_BITS-2:0], fits};
      rem_q <= fits ? 64'(trial - {1'b0, ub_q}) : trial[63:0];
    end
  end

endmodule

// ===== sv/kvu_dp.sv =====
// Datapath: scratch register file, shared multiplier and divider, vertex state.
// Depends on kvu_pkg, kvu_mul, kvu_div and assert_macros.svh.
`include "assert_macros.svh"
module kvu_dp
  import kvu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_stat_t            stat_o,
  input  cfg_t                cfg_i,
  input  logic signed [31:0]  slope_meas_i,
  input  logic signed [31:0]  intercept_meas_i,
  input  logic [31:0]         slope_error_i,
  input  logic [31:0]         intercept_error_i,
  input  logic                start_new_i,
  output logic signed [31:0]  vertex_x_o,
  output logic signed [31:0]  vertex_y_o,
  output logic [47:0]         cov_xx_o,
  output logic signed [47:0]  cov_xy_o,
  output logic [47:0]         cov_yy_o,
  output logic                status_o
);

  logic signed [63:0] rf [RF_DEPTH];
  logic signed [63:0] rd_a_q, rd_b_q;

  logic signed [31:0] mm_q, qm_q;
  logic [31:0]        me_q, qe_q;

  logic signed [31:0] vx_q, vy_q;
  logic [47:0]        cxx_q, cyy_q;
  logic signed [47:0] cxy_q;
  logic               bad_q;

  logic               mul_busy, mul_done, div_busy, div_done;
  logic signed [63:0] mul_res, div_res, ld_val;
  logic               we;
  logic signed [63:0] wd;
  logic               go_mul, go_div;
  op_e                op;

  assign op     = cmd_i.uop.op;
  assign go_mul = cmd_i.go && (op == OP_MUL);
  assign go_div = cmd_i.go && (op == OP_DIV);
  assign stat_o.busy = mul_busy | div_busy;

  kvu_mul u_mul (
    .clk_i, .rst_ni, .start_i(go_mul), .a_i(rd_a_q), .b_i(rd_b_q),
    .busy_o(mul_busy), .done_o(mul_done), .res_o(mul_res)
  );

  kvu_div u_div (
    .clk_i, .rst_ni, .start_i(go_div), .a_i(rd_a_q), .b_i(rd_b_q),
    .busy_o(div_busy), .done_o(div_done), .res_o(div_res)
  );

  // Operand loads, all scaled to Q.24
  always_comb begin
    unique case (cmd_i.uop.dst)
      R_PX:    ld_val = {{24{vx_q[31]}}, vx_q, 8'd0};
      R_PY:    ld_val = {{24{vy_q[31]}}, vy_q, 8'd0};
      R_CXX:   ld_val = {16'd0, cxx_q};
      R_CXY:   ld_val = {{16{cxy_q[47]}}, cxy_q};
      R_CYY:   ld_val = {16'd0, cyy_q};
      R_NS:    ld_val = -{{24{cfg_i.slope_ref[31]}}, cfg_i.slope_ref, 8'd0};
      R_XR:    ld_val = {{24{cfg_i.x_ref[31]}}, cfg_i.x_ref, 8'd0};
      R_MM:    ld_val = {{24{mm_q[31]}}, mm_q, 8'd0};
      R_QM:    ld_val = {{24{qm_q[31]}}, qm_q, 8'd0};
      R_ME:    ld_val = {24'd0, me_q, 8'd0};
      R_QE:    ld_val = {24'd0, qe_q, 8'd0};
      default: ld_val = '0;
    endcase
  end

  always_comb begin
    we = 1'b0;
    wd = '0;
    if (mul_done) begin
      we = 1'b1;
      wd = mul_res;
    end else if (div_done) begin
      we = 1'b1;
      wd = div_res;
    end else if (cmd_i.go) begin
      unique case (op)
        OP_LD: begin
          we = 1'b1;
          wd = ld_val;
        end
        OP_ADD: begin
          we = 1'b1;
          wd = sat_add(rd_a_q, rd_b_q);
        end
        OP_SUB: begin
          we = 1'b1;
          wd = sat_sub(rd_a_q, rd_b_q);
        end
        OP_CLU: begin
          we = 1'b1;
          wd = rd_a_q[63] ? '0 : ((rd_a_q > U48_MAX) ? U48_MAX : rd_a_q);
        end
        OP_CLS: begin
          we = 1'b1;
          wd = (rd_a_q < S48_MIN) ? S48_MIN : ((rd_a_q > S48_MAX) ? S48_MAX : rd_a_q);
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) rf[cmd_i.uop.dst] <= wd;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_a_q <= rf[cmd_i.uop.a];
      rd_b_q <= rf[cmd_i.uop.b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mm_q <= slope_meas_i;
      qm_q <= intercept_meas_i;
      me_q <= slope_error_i;
      qe_q <= intercept_error_i;
    end
    if (cmd_i.load_out) begin
      vertex_x_o <= vx_q;
      vertex_y_o <= vy_q;
      cov_xx_o   <= cxx_q;
      cov_xy_o   <= cxy_q;
      cov_yy_o   <= cyy_q;
      status_o   <= bad_q;
    end
  end

  // Vertex state: reseed on capture when start_new_i is set, commit only when no check has failed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vx_q  <= '0;
      vy_q  <= '0;
      cxx_q <= SEED_COV;
      cxy_q <= '0;
      cyy_q <= SEED_COV;
      bad_q <= 1'b0;
    end else if (cmd_i.capture) begin
      bad_q <= 1'b0;
      if (start_new_i) begin
        vx_q  <= cfg_i.seed_x;
        vy_q  <= cfg_i.seed_y;
        cxx_q <= SEED_COV;
        cxy_q <= '0;
        cyy_q <= SEED_COV;
      end
    end else if (cmd_i.go) begin
      unique case (op)
        OP_CHKZ: if (rd_a_q == '0) bad_q <= 1'b1;
        OP_WX:   if (!bad_q) vx_q <= to_q16(rd_a_q);
        OP_WY:   if (!bad_q) vy_q <= to_q16(rd_a_q);
        OP_WXX:  if (!bad_q) cxx_q <= rd_a_q[47:0];
        OP_WXY:  if (!bad_q) cxy_q <= rd_a_q[47:0];
        OP_WYY:  if (!bad_q) cyy_q <= rd_a_q[47:0];
        default: bad_q <= bad_q;
      endcase
    end
  end

  `KVU_ASSERT(a_units_excl, !(mul_busy && div_busy), "multiplier and divider both running")
  `KVU_ASSERT_NEXT(a_bad_clear, cmd_i.capture, !bad_q, "status not cleared on a new word")
  `KVU_ASSERT_NEXT(a_mul_start, go_mul, mul_busy, "multiplier did not start")

endmodule

// ===== sv/kvu_ctrl.sv =====
// Controller: steps the micro-program and runs both handshakes.
// Depends on kvu_pkg and assert_macros.svh.
`include "assert_macros.svh"
module kvu_ctrl
  import kvu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  ctrl_state_e state_q, state_d;
  pc_t         pc_q, pc_d;
  logic        out_valid_q, out_valid_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    pc_d           = pc_q;
    cmd_o          = '0;
    cmd_o.uop      = prog_row(pc_q);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          pc_d          = '0;
          state_d       = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.go = 1'b1;
        state_d  = S_WAIT;
      end
      S_WAIT: begin
        if (!stat_i.busy) begin
          if (pc_q == PROG_LAST) begin
            state_d = S_EMIT;
          end else begin
            pc_d    = pc_q + 6'd1;
            state_d = S_READ;
          end
        end
      end
      S_EMIT: begin
        // hold until the output word has gone
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  `KVU_ASSERT_NEXT(a_go_single, cmd_o.go, !cmd_o.go, "operation issued twice")
  `KVU_ASSERT(a_no_overwrite, cmd_o.load_out |-> (!out_valid_q || !out_stall_i), "output overwritten")
  `KVU_ASSERT(a_pc_range, (state_q != S_IDLE) |-> (pc_q <= PROG_LAST), "program counter out of range")

endmodule

// ===== sv/kalman_vertex_update_2d.sv =====
// Top level of the 2D Kalman vertex update: APB registers, controller, datapath.
// Depends on kvu_pkg, kvu_cfg, kvu_ctrl, kvu_dp.
//
//   channel  handshake               fields
//   input    in_valid_i / in_stall_o  slope/intercept, errors, start_new
//   output   out_valid_o / out_stall_i vertex, covariance, status
//   config   APB psel/penable/pwrite  4 x 32-bit registers at 0x0..0xC
//
// Each word runs 59 micro-ops, each read, issued and waited on in turn, among them 18
// multiplies and 2 divides; the bit-serial divides take the largest share of the time.
// After reset the state holds the zero vertex and seed covariance; no clearing pass.
// A new word is taken once the previous result sits in the output register.
// An output stall holds only the final hand-over of the next result.
module kalman_vertex_update_2d
  import kvu_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] slope_meas_i,
  input  logic signed [31:0] intercept_meas_i,
  input  logic [31:0]        slope_error_i,
  input  logic [31:0]        intercept_error_i,
  input  logic               start_new_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] vertex_x_o,
  output logic signed [31:0] vertex_y_o,
  output logic [47:0]        cov_xx_o,
  output logic signed [47:0] cov_xy_o,
  output logic [47:0]        cov_yy_o,
  output logic               status_o
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  kvu_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  kvu_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o(cmd), .stat_i(stat)
  );

  kvu_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .cfg_i(cfg),
    .slope_meas_i, .intercept_meas_i, .slope_error_i, .intercept_error_i, .start_new_i,
    .vertex_x_o, .vertex_y_o, .cov_xx_o, .cov_xy_o, .cov_yy_o, .status_o
  );

endmodule
